>>> rtl/assert_macros.svh
// Assertion macros shared by the segment light envelope RTL.
// Every macro samples on the rising edge of clock and is disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define SLE_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define SLE_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/slenv_pkg.sv
// Shared types and constants for the segment light envelope block.
// No dependencies; imported by every module of the block except slenv_ram.
`timescale 1ns / 1ps

package slenv_pkg;

   // table geometry
   localparam int PARTS         = 8;
   localparam int SEGS_PER_PART = 256;
   localparam int PART_W        = 3;
   localparam int SEG_W         = $clog2(SEGS_PER_PART);
   localparam int CNT_W         = $clog2(SEGS_PER_PART + 1);
   localparam int ADDR_W        = PART_W + SEG_W;
   localparam int RAM_DEPTH     = 2 ** ADDR_W;

   // field widths
   localparam int TIME_W     = 32;
   localparam int TYPE_W     = 2;
   localparam int LEVEL_W    = 12;
   localparam int SEG_WORD_W = 2 * TIME_W + TYPE_W;
   localparam int DIV_CNT_W  = $clog2(LEVEL_W);

   localparam logic [LEVEL_W-1:0] FULL_LEVEL = LEVEL_W'(4095);

   typedef enum logic [0:0] {
      CMD_APPEND = 1'b0,
      CMD_QUERY  = 1'b1
   } cmd_type;

   typedef enum logic [TYPE_W-1:0] {
      SEG_OFF      = 2'd0,
      SEG_FULL     = 2'd1,
      SEG_FADE_IN  = 2'd2,
      SEG_FADE_OUT = 2'd3
   } seg_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SEARCH,
      ST_SEARCH_WAIT,
      ST_FETCH_WAIT,
      ST_DIV_INIT,
      ST_DIVIDE,
      ST_RESPOND
   } ctrl_state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic append;
      logic query_init;
      logic search_issue;
      logic search_step;
      logic fetch_issue;
      logic eval;
      logic div_init;
      logic div_step;
      logic respond;
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_append;
      logic is_empty;
      logic search_done;
      logic need_div;
      logic div_last;
   } ctrl_status_type;

endpackage

>>> rtl/slenv_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module slenv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> rtl/slenv_ctrl.sv
// Controller state machine for the segment light envelope block.
// Depends on slenv_pkg and assert_macros.svh; drives the datapath by command structs.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module slenv_ctrl
   import slenv_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output ctrl_cmd_type    cmd,
   input  ctrl_status_type status
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           slot_free;

   // output register free to take a new result
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            priority if (status.is_append) state_in = ST_RESPOND;
            else if (status.is_empty)      state_in = ST_RESPOND;
            else                           state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            state_in = status.search_done ? ST_FETCH_WAIT : ST_SEARCH_WAIT;
         end
         ST_SEARCH_WAIT: begin
            state_in = ST_SEARCH;
         end
         ST_FETCH_WAIT: begin
            state_in = status.need_div ? ST_DIV_INIT : ST_RESPOND;
         end
         ST_DIV_INIT: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (status.div_last) state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE:        cmd.load        = req_valid;
         ST_DECODE: begin
            cmd.append     = status.is_append;
            cmd.query_init = !status.is_append && !status.is_empty;
         end
         ST_SEARCH: begin
            cmd.fetch_issue  = status.search_done;
            cmd.search_issue = !status.search_done;
         end
         ST_SEARCH_WAIT: cmd.search_step = 1'b1;
         ST_FETCH_WAIT:  cmd.eval        = 1'b1;
         ST_DIV_INIT:    cmd.div_init    = 1'b1;
         ST_DIVIDE:      cmd.div_step    = 1'b1;
         ST_RESPOND:     cmd.respond     = slot_free;
         default:        cmd             = '0;
      endcase
   end

   // result valid flag: set on a new result, held while stalled
   assign rsp_valid_in = cmd.respond || (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `SLE_ASSERT_NXT(a_accept_decode, req_valid && !req_stall, state_ff == ST_DECODE, "accepted beat did not reach decode")
   `SLE_ASSERT_NXT(a_div_respond, state_ff == ST_DIVIDE && status.div_last, state_ff == ST_RESPOND, "divider finished without a response")

endmodule

>>> rtl/slenv_dp.sv
// Datapath: segment table memory, per-part counts, binary search and ramp divider.
// Depends on slenv_pkg, slenv_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module slenv_dp
   import slenv_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_cmd,
   input  logic [PART_W-1:0]        req_part,
   input  logic signed [TIME_W-1:0] req_seg_start,
   input  logic signed [TIME_W-1:0] req_seg_end,
   input  logic [TYPE_W-1:0]        req_seg_type,
   input  logic signed [TIME_W-1:0] req_query_time,
   output logic [LEVEL_W-1:0]       rsp_level,
   output logic                     rsp_status,
   input  ctrl_cmd_type             cmd,
   output ctrl_status_type          status
);

   // captured beat
   cmd_type                   cmd_ff;
   logic [PART_W-1:0]         part_ff;
   logic signed [TIME_W-1:0]  start_ff, end_ff, time_ff;
   logic [TYPE_W-1:0]         type_ff;

   // per-part fill counts
   logic [CNT_W-1:0] count_ff [PARTS];
   logic [CNT_W-1:0] cur_count;
   logic             part_ok, full, ram_we;

   // search
   logic [SEG_W-1:0] lo_ff, hi_ff, mid_ff, mid;
   logic [SEG_W:0]   mid_sum;

   // memory
   logic                  rd_en;
   logic [ADDR_W-1:0]     rd_addr;
   logic [SEG_WORD_W-1:0] rd_data;
   logic signed [TIME_W-1:0] rd_start, rd_end;
   logic [TYPE_W-1:0]     rd_type;

   // evaluation
   logic              in_window, is_ramp, full_on;
   logic [TIME_W:0]   span_wide, num_wide;
   logic [TIME_W-1:0] span_ff, num_ff;

   // divider
   logic [TIME_W+LEVEL_W-1:0] scaled;
   logic [TIME_W-1:0]         rem_ff;
   logic [LEVEL_W-1:0]        low_ff;
   logic [TIME_W:0]           trial, diff;
   logic                      ge;
   logic [DIV_CNT_W-1:0]      div_cnt_ff;

   // result
   logic [LEVEL_W-1:0] level_ff, rsp_level_ff;
   logic               status_ff, rsp_status_ff;

   // count lookup and table-full check
   assign part_ok   = int'(part_ff) < PARTS;
   assign cur_count = count_ff[part_ff];
   assign full      = !part_ok || (cur_count >= CNT_W'(SEGS_PER_PART));
   assign ram_we    = cmd.append && !full;

   // upper midpoint of the search window
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff} + (SEG_W+1)'(1);
   assign mid     = mid_sum[SEG_W:1];

   assign rd_en   = cmd.search_issue || cmd.fetch_issue;
   assign rd_addr = cmd.search_issue ? {part_ff, mid} : {part_ff, lo_ff};

   slenv_ram #(
      .WIDTH (SEG_WORD_W),
      .DEPTH (RAM_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr ({part_ff, cur_count[SEG_W-1:0]}),
      .wr_data ({start_ff, end_ff, type_ff}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_start = rd_data[SEG_WORD_W-1 -: TIME_W];
   assign rd_end   = rd_data[TYPE_W +: TIME_W];
   assign rd_type  = rd_data[TYPE_W-1:0];

   // segment classification against the query time
   always_comb begin
      in_window = (rd_start <= time_ff) && (time_ff <= rd_end);
      is_ramp   = (rd_type == SEG_FADE_IN) || (rd_type == SEG_FADE_OUT);
      span_wide = {rd_end[TIME_W-1], rd_end} - {rd_start[TIME_W-1], rd_start};
      if (rd_type == SEG_FADE_IN) begin
         num_wide = {time_ff[TIME_W-1], time_ff} - {rd_start[TIME_W-1], rd_start};
      end else begin
         num_wide = {rd_end[TIME_W-1], rd_end} - {time_ff[TIME_W-1], time_ff};
      end
      full_on = in_window && ((rd_type == SEG_FULL) ||
                              (is_ramp && (span_wide[TIME_W-1:0] == '0)));
   end

   // one restoring step: 4095 * num is (num << 12) - num
   assign scaled = {num_ff, LEVEL_W'(0)} - {LEVEL_W'(0), num_ff};
   assign trial  = {rem_ff, low_ff[LEVEL_W-1]};
   assign diff   = trial - {1'b0, span_ff};
   assign ge     = (trial >= {1'b0, span_ff});

   // captured beat, search window, divider and result
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff    <= cmd_type'(req_cmd);
         part_ff   <= req_part;
         start_ff  <= req_seg_start;
         end_ff    <= req_seg_end;
         type_ff   <= req_seg_type;
         time_ff   <= req_query_time;
         level_ff  <= '0;
         status_ff <= 1'b0;
      end
      if (cmd.append) begin
         status_ff <= full;
      end
      if (cmd.query_init) begin
         lo_ff <= '0;
         hi_ff <= SEG_W'(cur_count - CNT_W'(1));
      end
      if (cmd.search_issue) begin
         mid_ff <= mid;
      end
      if (cmd.search_step) begin
         if (rd_start > time_ff) hi_ff <= mid_ff - SEG_W'(1);
         else                    lo_ff <= mid_ff;
      end
      if (cmd.eval) begin
         level_ff <= full_on ? FULL_LEVEL : '0;
         span_ff  <= span_wide[TIME_W-1:0];
         num_ff   <= num_wide[TIME_W-1:0];
      end
      if (cmd.div_init) begin
         rem_ff     <= scaled[TIME_W+LEVEL_W-1:LEVEL_W];
         low_ff     <= scaled[LEVEL_W-1:0];
         level_ff   <= '0;
         div_cnt_ff <= DIV_CNT_W'(LEVEL_W - 1);
      end
      if (cmd.div_step) begin
         rem_ff     <= ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
         low_ff     <= {low_ff[LEVEL_W-2:0], 1'b0};
         level_ff   <= {level_ff[LEVEL_W-2:0], ge};
         div_cnt_ff <= div_cnt_ff - DIV_CNT_W'(1);
      end
      if (cmd.respond) begin
         rsp_level_ff  <= level_ff;
         rsp_status_ff <= status_ff;
      end
   end

   // per-part counts
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PARTS; i++) begin
            count_ff[i] <= '0;
         end
      end else if (ram_we) begin
         count_ff[part_ff] <= cur_count + CNT_W'(1);
      end
   end

   assign status.is_append   = (cmd_ff == CMD_APPEND);
   assign status.is_empty    = !part_ok || (cur_count == '0);
   assign status.search_done = (lo_ff == hi_ff);
   assign status.need_div    = in_window && is_ramp && (span_wide[TIME_W-1:0] != '0);
   assign status.div_last    = (div_cnt_ff == '0);

   assign rsp_level  = rsp_level_ff;
   assign rsp_status = rsp_status_ff;

   `SLE_ASSERT_NXT(a_search_order, cmd.search_step, lo_ff <= hi_ff, "search window inverted")
   `SLE_ASSERT_NXT(a_rem_below_span, cmd.div_step, rem_ff < span_ff, "divider remainder not below span")
   `SLE_ASSERT_IMP(a_no_write_full, ram_we, !full, "segment written into a full table")

endmodule

>>> rtl/segment_light_envelope.sv
// Segment light envelope: per-part segment tables appended and queried for a brightness level.
// The block takes one beat at a time. An append goes through decode to a valid result.
// A query goes through decode, then binary-search steps (ceil(log2 n) steps for n stored
// segments, at most 8), each a registered memory read and a window update, then a fetch
// of the chosen segment and, for a fade ramp, a divider set-up and one step per level bit.
// The next beat is taken in the cycle after the result is issued; a result still held
// by an output stall delays the issue of the following one.
// The search is paced by the single-read-port segment memory with its registered
// read, and the ramp by a restoring divider that makes one level bit per cycle.
// Depends on slenv_pkg, slenv_ctrl and slenv_dp.
`timescale 1ns / 1ps

module segment_light_envelope
   import slenv_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_cmd,
   input  logic [PART_W-1:0]        req_part,
   input  logic signed [TIME_W-1:0] req_seg_start,
   input  logic signed [TIME_W-1:0] req_seg_end,
   input  logic [TYPE_W-1:0]        req_seg_type,
   input  logic signed [TIME_W-1:0] req_query_time,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [LEVEL_W-1:0]       rsp_level,
   output logic                     rsp_status
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // sequencer
   slenv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // tables, search and divider
   slenv_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_cmd        (req_cmd),
      .req_part       (req_part),
      .req_seg_start  (req_seg_start),
      .req_seg_end    (req_seg_end),
      .req_seg_type   (req_seg_type),
      .req_query_time (req_query_time),
      .rsp_level      (rsp_level),
      .rsp_status     (rsp_status),
      .cmd            (cmd),
      .status         (status)
   );

endmodule
